// ===== rtl/core/ktuf_pkg.sv =====
// ----------------------------------------------------------------------------
// ktuf_pkg
// Item types and codes shared by the reconstruction tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ktuf_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_JOINED = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [10:0] node_a;
    logic [10:0] node_b;
    logic [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] new_node;
    logic [10:0] parent_node;
    logic [15:0] node_weight_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/kruskal_tree_union_find_builder.sv =====
// ----------------------------------------------------------------------------
// kruskal_tree_union_find_builder
// Kruskal reconstruction tree over a disjoint-set store held in memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add item joins two
// leaves; a read item returns a node's tree parent and weight. Each item gives
// exactly one result, shown on out_item for one cycle with out_valid high;
// the receiver cannot stall it.
// Bad indexes answer in the cycle after the item is taken. A read answers
// through the tree memory's registered read port and the output register. An
// add walks each find path twice through the set memory's single read port:
// up to the root, then back along the path for compression, first for leaf
// a and then for leaf b. The merge states S_TA, S_TB and S_FIN follow and
// the result is registered out; an already joined edge ends after its second
// compression pass, without the merge states. The next item can be taken at
// the edge that ends the result cycle.
// After reset the block runs a clearing pass over all 2*LEAF_COUNT entries of
// both memories with busy high; no item is taken until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_tree_union_find_builder
  import ktuf_pkg::*;
#(
  parameter int LEAF_COUNT  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int NODE_TOTAL = 2 * LEAF_COUNT;
  localparam int NB = $clog2(NODE_TOTAL);
  localparam int WB = WEIGHT_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FW    = 3'd2;
  localparam logic [2:0] S_CW    = 3'd3;
  localparam logic [2:0] S_TA    = 3'd4;
  localparam logic [2:0] S_TB    = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_RD    = 3'd7;

  typedef struct packed {
    logic [NB-1:0] link;
    logic [NB-1:0] size;
    logic [NB-1:0] troot;
  } ds_word_t;

  typedef struct packed {
    logic [WB-1:0] weight;
    logic [NB-1:0] parent;
  } tr_word_t;

  logic [2:0]    state_r, state_nxt;
  logic [NB-1:0] clr_r, clr_nxt;
  logic [NB:0]   next_node_r, next_node_nxt;
  logic [NB-1:0] cur_r, cur_nxt, start_r, start_nxt, top_r, top_nxt;
  logic          sel_r, sel_nxt;
  logic [NB-1:0] ra_r, ra_nxt, sa_r, sa_nxt, ta_r, ta_nxt;
  logic [NB-1:0] rb_r, rb_nxt, sb_r, sb_nxt, tb_r, tb_nxt;
  logic [NB-1:0] t1_r, t1_nxt, sa1_r, sa1_nxt;
  logic [WB-1:0] wt1_r, wt1_nxt, wgt_r, wgt_nxt;
  logic [NB-1:0] root_r, root_nxt, ssum_r, ssum_nxt, froot_r, froot_nxt;
  logic          nnw_r, nnw_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          ds_we, tr_we;
  logic [NB-1:0] ds_waddr, ds_raddr, tr_waddr, tr_raddr;
  ds_word_t      ds_wdata, ds_rdata;
  tr_word_t      tr_wdata, tr_rdata;

  logic [NB-1:0] nn;
  logic [NB-1:0] na_idx, nb_idx;
  logic          m2_keep_a;
  logic [NB-1:0] x_t, y_t, child;
  logic [WB-1:0] wx, wy;

  assign nn     = next_node_r[NB-1:0];
  assign na_idx = NB'(in_item.node_a);
  assign nb_idx = NB'(in_item.node_b);

  ktuf_ram #(.WIDTH($bits(ds_word_t)), .DEPTH(NODE_TOTAL)) u_ds_ram (
    .clk   (clk),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (ds_wdata),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  ktuf_ram #(.WIDTH($bits(tr_word_t)), .DEPTH(NODE_TOTAL)) u_tr_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (tr_wdata),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  // Second merge: the first set root stays only if the other set is smaller.
  always_comb begin
    m2_keep_a = sb_r < sa1_r;
    if (m2_keep_a) begin
      x_t = t1_r;
      y_t = tb_r;
      wx  = wt1_r;
      wy  = tr_rdata.weight;
      child = rb_r;
    end else begin
      x_t = tb_r;
      y_t = t1_r;
      wx  = tr_rdata.weight;
      wy  = wt1_r;
      child = ra_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    next_node_nxt = next_node_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    top_nxt       = top_r;
    sel_nxt       = sel_r;
    ra_nxt        = ra_r;
    sa_nxt        = sa_r;
    ta_nxt        = ta_r;
    rb_nxt        = rb_r;
    sb_nxt        = sb_r;
    tb_nxt        = tb_r;
    t1_nxt        = t1_r;
    sa1_nxt       = sa1_r;
    wt1_nxt       = wt1_r;
    wgt_nxt       = wgt_r;
    root_nxt      = root_r;
    ssum_nxt      = ssum_r;
    froot_nxt     = froot_r;
    nnw_nxt       = nnw_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    ds_we         = 1'b0;
    ds_waddr      = cur_r;
    ds_wdata      = '0;
    ds_raddr      = cur_r;
    tr_we         = 1'b0;
    tr_waddr      = cur_r;
    tr_wdata      = '0;
    tr_raddr      = cur_r;

    unique case (state_r)
      S_CLEAR: begin
        ds_we    = 1'b1;
        ds_waddr = clr_r;
        ds_wdata = '{link: clr_r, size: NB'(1), troot: clr_r};
        tr_we    = 1'b1;
        tr_waddr = clr_r;
        tr_wdata = '{weight: '0, parent: clr_r};
        clr_nxt  = clr_r + NB'(1);
        if (clr_r == NB'(NODE_TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        ds_raddr = na_idx;
        tr_raddr = na_idx;
        if (start) begin
          if (in_item.opcode == OP_READ) begin
            if (32'(in_item.node_a) >= 32'(NODE_TOTAL)) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_BAD;
            end else begin
              state_nxt = S_RD;
            end
          end else if (32'(in_item.node_a) >= 32'(LEAF_COUNT) ||
                       32'(in_item.node_b) >= 32'(LEAF_COUNT)) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ST_BAD;
          end else begin
            cur_nxt   = na_idx;
            start_nxt = na_idx;
            sel_nxt   = 1'b0;
            rb_nxt    = nb_idx;
            wgt_nxt   = WB'(32'(in_item.edge_weight));
            state_nxt = S_FW;
          end
        end
      end

      S_RD: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.parent_node     = 11'(tr_rdata.parent);
        out_item_nxt.node_weight_out = 16'(tr_rdata.weight);
        state_nxt                    = S_IDLE;
      end

      // Walk up to the set root, one link a cycle.
      S_FW: begin
        if (ds_rdata.link == cur_r) begin
          top_nxt  = cur_r;
          cur_nxt  = start_r;
          ds_raddr = start_r;
          if (!sel_r) begin
            ra_nxt = cur_r;
            sa_nxt = ds_rdata.size;
            ta_nxt = ds_rdata.troot;
          end else begin
            rb_nxt = cur_r;
            sb_nxt = ds_rdata.size;
            tb_nxt = ds_rdata.troot;
          end
          state_nxt = S_CW;
        end else begin
          cur_nxt  = ds_rdata.link;
          ds_raddr = ds_rdata.link;
        end
      end

      // Second pass over the path points every node at the root.
      S_CW: begin
        if (ds_rdata.link != top_r && cur_r != top_r) begin
          ds_we    = 1'b1;
          ds_waddr = cur_r;
          ds_wdata = '{link: top_r, size: ds_rdata.size, troot: ds_rdata.troot};
          cur_nxt  = ds_rdata.link;
          ds_raddr = ds_rdata.link;
        end else if (!sel_r) begin
          sel_nxt   = 1'b1;
          cur_nxt   = rb_r;
          start_nxt = rb_r;
          ds_raddr  = rb_r;
          state_nxt = S_FW;
        end else if (ra_r == top_r) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_JOINED;
          state_nxt           = S_IDLE;
        end else if (next_node_r >= (NB+1)'(NODE_TOTAL)) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_BAD;
          state_nxt           = S_IDLE;
        end else begin
          tr_raddr  = ta_r;
          state_nxt = S_TA;
        end
      end

      // First merge: the new node joins the first set as a single member.
      S_TA: begin
        tr_raddr = tb_r;
        ds_we    = 1'b1;
        ds_waddr = nn;
        ds_wdata = '{link: ra_r, size: NB'(1), troot: nn};
        tr_we    = 1'b1;
        sa1_nxt  = sa_r + NB'(1);
        if (tr_rdata.weight < wgt_r) begin
          tr_waddr = ta_r;
          tr_wdata = '{weight: tr_rdata.weight, parent: nn};
          t1_nxt   = nn;
          wt1_nxt  = wgt_r;
        end else begin
          tr_waddr = nn;
          tr_wdata = '{weight: wgt_r, parent: ta_r};
          t1_nxt   = ta_r;
          wt1_nxt  = tr_rdata.weight;
        end
        state_nxt = S_TB;
      end

      S_TB: begin
        root_nxt = m2_keep_a ? ra_r : rb_r;
        ssum_nxt = sa1_r + sb_r;
        tr_we    = 1'b1;
        if (wx < wy) begin
          tr_waddr  = x_t;
          tr_wdata  = '{weight: wx, parent: y_t};
          froot_nxt = y_t;
        end else begin
          tr_waddr  = y_t;
          tr_wdata  = '{weight: wy, parent: x_t};
          froot_nxt = x_t;
        end
        // A new node that stays a tree root still has no weight in memory.
        nnw_nxt   = (t1_r == nn) && (tr_waddr != nn);
        ds_we     = 1'b1;
        ds_waddr  = child;
        ds_wdata  = '{link: root_nxt, size: ssum_nxt, troot: froot_nxt};
        state_nxt = S_FIN;
      end

      S_FIN: begin
        ds_we                 = 1'b1;
        ds_waddr              = root_r;
        ds_wdata              = '{link: root_r, size: ssum_r, troot: froot_r};
        if (nnw_r) begin
          tr_we    = 1'b1;
          tr_waddr = nn;
          tr_wdata = '{weight: wgt_r, parent: nn};
        end
        out_valid_nxt         = 1'b1;
        out_item_nxt.status   = ST_OK;
        out_item_nxt.new_node = 11'(nn);
        next_node_nxt         = next_node_r + (NB+1)'(1);
        state_nxt             = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_node_r <= (NB+1)'(LEAF_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_node_r <= next_node_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    start_r    <= start_nxt;
    top_r      <= top_nxt;
    sel_r      <= sel_nxt;
    ra_r       <= ra_nxt;
    sa_r       <= sa_nxt;
    ta_r       <= ta_nxt;
    rb_r       <= rb_nxt;
    sb_r       <= sb_nxt;
    tb_r       <= tb_nxt;
    t1_r       <= t1_nxt;
    sa1_r      <= sa1_nxt;
    wt1_r      <= wt1_nxt;
    wgt_r      <= wgt_nxt;
    root_r     <= root_nxt;
    ssum_r     <= ssum_nxt;
    froot_r    <= froot_nxt;
    nnw_r      <= nnw_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result shown during clearing pass");

  a_accept_makes_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("accepted item neither started nor answered");

  a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_node_r <= (NB+1)'(NODE_TOTAL))
    else $error("node counter beyond node space");

  a_set_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ds_we |-> busy)
    else $error("set memory written while idle");

endmodule

`default_nettype wire

// ===== rtl/core/ktuf_ram.sv =====
// ----------------------------------------------------------------------------
// ktuf_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ktuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reconstruction tree builder: a directed table
// of edges and reads, then random edge and read sequences, checked against a
// behavioral union-find predictor item by item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ktuf_pkg::*;

  localparam int LEAVES    = 1024;
  localparam int NODES     = 2 * LEAVES;
  localparam int WATCHDOG  = 20000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  kruskal_tree_union_find_builder #(.LEAF_COUNT(LEAVES), .WEIGHT_BITS(16)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state.
  logic [10:0] p_link   [NODES];
  logic [11:0] p_size   [NODES];
  logic [10:0] p_troot  [NODES];
  logic [15:0] p_weight [NODES];
  logic [10:0] p_tpar   [NODES];
  int          p_next;

  out_item_t result_queue[$];
  int        mismatches;
  int        idle_cycles;
  logic      timed_out;

  function automatic logic [10:0] find_root(input logic [10:0] v);
    logic [10:0] top;
    logic [10:0] walk;
    logic [10:0] up;
    top = v;
    while (p_link[top] != top) top = p_link[top];
    walk = v;
    while (p_link[walk] != top && walk != top) begin
      up = p_link[walk];
      p_link[walk] = top;
      walk = up;
    end
    return top;
  endfunction

  function automatic void join_sets(input logic [10:0] x, input logic [10:0] y);
    logic [10:0] ra;
    logic [10:0] rb;
    logic [10:0] t;
    logic [10:0] ta;
    logic [10:0] tb;
    ra = find_root(x);
    rb = find_root(y);
    if (ra == rb) return;
    if (p_size[ra] < p_size[rb]) begin
      t = ra;
      ra = rb;
      rb = t;
    end
    p_link[rb] = ra;
    p_size[ra] = p_size[ra] + p_size[rb];
    ta = p_troot[ra];
    tb = p_troot[rb];
    if (p_weight[ta] < p_weight[tb]) begin
      p_tpar[ta] = tb;
      p_troot[ra] = tb;
    end else begin
      p_tpar[tb] = ta;
      p_troot[rb] = ta;
    end
  endfunction

  function automatic out_item_t tree_step(input in_item_t it);
    out_item_t r;
    logic [10:0] ra;
    logic [10:0] rb;
    r = '0;
    if (it.opcode == OP_READ) begin
      r.parent_node     = p_tpar[it.node_a];
      r.node_weight_out = p_weight[it.node_a];
    end else if (it.node_a >= LEAVES || it.node_b >= LEAVES) begin
      r.status = ST_BAD;
    end else begin
      ra = find_root(it.node_a);
      rb = find_root(it.node_b);
      if (ra == rb) r.status = ST_JOINED;
      else if (p_next >= NODES) r.status = ST_BAD;
      else begin
        p_weight[p_next] = it.edge_weight;
        join_sets(ra, 11'(p_next));
        join_sets(rb, 11'(p_next));
        r.new_node = 11'(p_next);
        p_next++;
      end
    end
    return r;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        if (out_item !== result_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d nn=%0d par=%0d w=%0d got st=%0d nn=%0d par=%0d w=%0d",
                     result_queue[0].status, result_queue[0].new_node,
                     result_queue[0].parent_node, result_queue[0].node_weight_out,
                     out_item.status, out_item.new_node, out_item.parent_node,
                     out_item.node_weight_out);
        end
        void'(result_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one item and waits until it is taken. Start stays high into the
  // next item when that one has no gap. An item that carries a fixed expected
  // result is checked against the predictor and queued in place of the prediction.
  task automatic send_item(input in_item_t it, input logic use_fixed,
                           input out_item_t fixed);
    out_item_t pred;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = tree_step(it);
    if (use_fixed && pred !== fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor");
    end
    if (use_fixed) pred = fixed;
    result_queue = {result_queue, pred};
  endtask

  function automatic in_item_t mk(input logic op, input int a, input int b, input int w);
    in_item_t it;
    it.opcode = op;
    it.node_a = 11'(a);
    it.node_b = 11'(b);
    it.edge_weight = 16'(w);
    return it;
  endfunction

  function automatic out_item_t mo(input logic [1:0] st, input int nn, input int par,
                                   input int w);
    out_item_t r;
    r.status = st;
    r.new_node = 11'(nn);
    r.parent_node = 11'(par);
    r.node_weight_out = 16'(w);
    return r;
  endfunction

  typedef struct {
    in_item_t  it;
    logic      fixed;
    out_item_t res;
  } row_t;

  row_t table_rows[$];

  task automatic add_row(input in_item_t it, input logic fixed, input out_item_t res);
    row_t row;
    row.it    = it;
    row.fixed = fixed;
    row.res   = res;
    table_rows = {table_rows, row};
  endtask

  initial begin
    in_item_t it;
    int base;
    int pick;
    mismatches = 0;
    idle_cycles = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    for (int i = 0; i < NODES; i++) begin
      p_link[i] = 11'(i); p_size[i] = 1; p_troot[i] = 11'(i);
      p_weight[i] = 0; p_tpar[i] = 11'(i);
    end
    p_next = LEAVES;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; the fixed rows follow from reset state and the rows before them.
    add_row(mk(OP_READ, 0, 0, 0), 1'b1, mo(ST_OK, 0, 0, 0));
    add_row(mk(OP_READ, 2047, 2047, 16'hffff), 1'b1, mo(ST_OK, 0, 2047, 0));
    add_row(mk(OP_READ, 1500, 0, 0), 1'b1, mo(ST_OK, 0, 1500, 0));
    add_row(mk(OP_ADD, 1024, 0, 5), 1'b1, mo(ST_BAD, 0, 0, 0));
    add_row(mk(OP_ADD, 0, 2047, 5), 1'b1, mo(ST_BAD, 0, 0, 0));
    add_row(mk(OP_ADD, 3, 3, 9), 1'b1, mo(ST_JOINED, 0, 0, 0));
    add_row(mk(OP_ADD, 0, 1023, 16'hffff), 1'b1, mo(ST_OK, 1024, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0), 1'b1, mo(ST_OK, 0, 1024, 0));
    add_row(mk(OP_READ, 1024, 0, 0), 1'b1, mo(ST_OK, 0, 1024, 16'hffff));
    add_row(mk(OP_ADD, 1023, 0, 7), 1'b1, mo(ST_JOINED, 0, 0, 0));
    add_row(mk(OP_ADD, 1, 2, 0), 1'b0, '0);
    add_row(mk(OP_ADD, 2, 0, 100), 1'b0, '0);
    add_row(mk(OP_ADD, 4, 5, 100), 1'b0, '0);
    add_row(mk(OP_ADD, 5, 1, 100), 1'b0, '0);
    add_row(mk(OP_READ, 1025, 0, 0), 1'b0, '0);
    add_row(mk(OP_READ, 1026, 0, 0), 1'b0, '0);
    add_row(mk(OP_READ, 1027, 0, 0), 1'b0, '0);
    add_row(mk(OP_READ, 2, 0, 0), 1'b0, '0);
    foreach (table_rows[i]) send_item(table_rows[i].it, table_rows[i].fixed, table_rows[i].res);
    start <= 1'b0;

    // Pause until the block has answered everything.
    wait (result_queue.size() == 0);

    // Random part: mostly edges among a moving window of leaves so sets grow
    // deep, plus reads of any node and some bad indexes.
    base = 8;
    for (int n = 0; n < 1750; n++) begin
      if (n % 150 == 0) base = $urandom_range(8, LEAVES - 64);
      pick = $urandom_range(0, 99);
      if (pick < 60)
        it = mk(OP_ADD, base + $urandom_range(0, 63), base + $urandom_range(0, 63),
                $urandom);
      else if (pick < 70)
        it = mk(OP_ADD, $urandom_range(0, LEAVES - 1), $urandom_range(0, LEAVES - 1),
                $urandom);
      else if (pick < 75)
        it = mk(OP_ADD, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
      else if (pick < 85)
        it = mk(OP_READ, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
      else
        it = mk(OP_READ, $urandom_range(LEAVES, p_next), $urandom_range(0, 2047),
                $urandom);
      send_item(it, 1'b0, '0);
    end
    start <= 1'b0;

    wait (result_queue.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== kruskal_tree_union_find_builder.f =====
rtl/core/ktuf_pkg.sv
rtl/core/ktuf_ram.sv
rtl/core/kruskal_tree_union_find_builder.sv
tb/tb_top.sv
